[hdl/kvpt_pkg.sv]
// Package for the key/value pair tokenizer: phase and kind codes,
// character constants, state and result structs, and character helpers.
// No dependencies.
package kvpt_pkg;

	localparam int DEPTH_BITS_DEF = 8;

	typedef enum logic [2:0] {
		PH_SKIP    = 3'd0,
		PH_NAME    = 3'd1,
		PH_VSTART  = 3'd2,
		PH_QUOTED  = 3'd3,
		PH_PLAIN   = 3'd4,
		PH_DISCARD = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_NAME_CHAR  = 3'd0,
		K_NAME_END   = 3'd1,
		K_VALUE_CHAR = 3'd2,
		K_VALUE_END  = 3'd3,
		K_NO_EQUALS  = 3'd4,
		K_NO_VALUE   = 3'd5,
		K_UNTERM     = 3'd6,
		K_OVERFLOW   = 3'd7
	} kind_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_RANGLE = 8'h3E;

	// Per-pair parse state except the nesting depth, whose width is a parameter
	typedef struct packed {
		phase_t     phase;
		logic [7:0] opening;
		logic [7:0] closing;
		logic       esc;
	} pstate_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_v;
		kind_t      kind;
	} result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// A space back means the byte opens no quoted or bracketed form
	function automatic logic [7:0] closer_of(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			CH_SQUOTE: r = CH_SQUOTE;
			CH_DQUOTE: r = CH_DQUOTE;
			CH_LBRACE: r = CH_RBRACE;
			CH_LBRACK: r = CH_RBRACK;
			CH_LPAREN: r = CH_RPAREN;
			CH_LANGLE: r = CH_RANGLE;
			default:   r = CH_SPACE;
		endcase
		return r;
	endfunction

endpackage

[hdl/kvpt_if.sv]
// Valid/ready channel interfaces for the tokenizer input bytes and results.
// Depends on nothing.
interface kvpt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       is_end;

	modport source (output valid, output byte_in, output is_end, input ready);
	modport sink   (input valid, input byte_in, input is_end, output ready);
endinterface

interface kvpt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [2:0] out_kind;

	modport source (output valid, output out_char, output out_kind, input ready);
	modport sink   (input valid, input out_char, input out_kind, output ready);
endinterface

[hdl/kvpt_step.sv]
// Next-state and result logic of the tokenizer for one byte or end mark.
// Depends on kvpt_pkg.
module kvpt_step import kvpt_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  pstate_t               cur,
	input  logic [DEPTH_BITS-1:0] depth,
	input  logic [7:0]            byte_in,
	input  logic                  is_end,
	output pstate_t               nxt,
	output logic [DEPTH_BITS-1:0] depth_nxt,
	output result_t               res
);

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

	logic [7:0]            closer;
	logic [DEPTH_BITS-1:0] depth_dec;

	assign closer    = closer_of(byte_in);
	assign depth_dec = depth - DEPTH_ONE;

	always_comb begin
		nxt       = cur;
		depth_nxt = depth;
		res       = '{valid: 1'b0, char_v: 8'h00, kind: K_NAME_CHAR};
		if (is_end) begin
			nxt       = '{phase: PH_SKIP, opening: 8'h00, closing: CH_SPACE, esc: 1'b0};
			depth_nxt = '0;
			unique case (cur.phase)
				PH_NAME:   res = '{valid: 1'b1, char_v: 8'h00, kind: K_NO_EQUALS};
				PH_VSTART: res = '{valid: 1'b1, char_v: 8'h00, kind: K_NO_VALUE};
				PH_QUOTED: res = '{valid: 1'b1, char_v: 8'h00, kind: K_UNTERM};
				PH_PLAIN:  res = '{valid: 1'b1, char_v: 8'h00, kind: K_VALUE_END};
				default:   res.valid = 1'b0;
			endcase
		end else begin
			unique case (cur.phase)
				PH_SKIP, PH_NAME: begin
					if (byte_in == CH_EQUALS) begin
						nxt.phase = PH_VSTART;
						res = '{valid: 1'b1, char_v: 8'h00, kind: K_NAME_END};
					end else if (cur.phase == PH_NAME || !is_ws(byte_in)) begin
						nxt.phase = PH_NAME;
						res = '{valid: 1'b1, char_v: byte_in, kind: K_NAME_CHAR};
					end
				end
				PH_VSTART: begin
					nxt.opening = byte_in;
					nxt.closing = closer;
					nxt.esc     = 1'b0;
					if (closer != CH_SPACE) begin
						depth_nxt = DEPTH_ONE;
						nxt.phase = PH_QUOTED;
					end else begin
						depth_nxt = '0;
						priority if (byte_in == CH_SPACE) begin
							nxt.phase = PH_SKIP;
							res = '{valid: 1'b1, char_v: 8'h00, kind: K_VALUE_END};
						end else if (byte_in == CH_BSLASH) begin
							nxt.phase = PH_PLAIN;
							nxt.esc   = 1'b1;
						end else begin
							nxt.phase = PH_PLAIN;
							res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
						end
					end
				end
				PH_QUOTED: begin
					// closer is tested before opener so a single quote closes
					priority if (cur.esc) begin
						nxt.esc = 1'b0;
						res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
					end else if (byte_in == cur.closing) begin
						depth_nxt = depth_dec;
						if (depth_dec == '0) begin
							nxt.phase = PH_SKIP;
							res = '{valid: 1'b1, char_v: 8'h00, kind: K_VALUE_END};
						end else begin
							res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
						end
					end else if (byte_in == cur.opening) begin
						if (depth == DEPTH_MAX) begin
							nxt.phase = PH_DISCARD;
							res = '{valid: 1'b1, char_v: 8'h00, kind: K_OVERFLOW};
						end else begin
							depth_nxt = depth + DEPTH_ONE;
							res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
						end
					end else if (byte_in == CH_BSLASH) begin
						nxt.esc = 1'b1;
					end else begin
						res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
					end
				end
				PH_PLAIN: begin
					priority if (cur.esc) begin
						nxt.esc = 1'b0;
						res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
					end else if (byte_in == CH_SPACE) begin
						nxt.phase = PH_SKIP;
						res = '{valid: 1'b1, char_v: 8'h00, kind: K_VALUE_END};
					end else if (byte_in == CH_BSLASH) begin
						nxt.esc = 1'b1;
					end else begin
						res = '{valid: 1'b1, char_v: byte_in, kind: K_VALUE_CHAR};
					end
				end
				PH_DISCARD: res.valid = 1'b0;
				default:    res.valid = 1'b0;
			endcase
		end
	end

endmodule

[hdl/key_value_pair_tokenizer.sv]
// Top level of the key/value pair tokenizer: parse state registers and the
// result register. Depends on kvpt_pkg, kvpt_if.sv and kvpt_step.
//
// Usage: bytes of a name=value string enter on in_ch, one per transaction;
// a transaction with is_end set closes the string (byte_in is ignored).
// Each transaction yields zero or one result on out_ch: out_kind tells a
// name char, name end, value char, value end or one of four errors, and
// out_char carries the byte for char kinds, else zero. After an
// unterminated result the receiver drops the value chars since the last
// name end.
// Throughput: one byte per cycle while no result is stalled on out_ch. The
// parse state update for a byte is a single pass of compare logic into the
// state registers, so bytes may follow back to back. A result is registered
// and appears on out_ch in the cycle after its byte is taken.
// Stall: the result register holds while out_ch.ready is low, and in_ch
// stays ready as long as that register is empty or being drained in the
// same cycle; while a result waits, no further byte is taken.
// Reset: arst_n clears the parse state to the leading-whitespace phase with
// zero nesting depth and empties the result register; no clearing pass.
module key_value_pair_tokenizer import kvpt_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	kvpt_in_if.sink    in_ch,
	kvpt_out_if.source out_ch
);

	pstate_t               st_q, st_nxt;
	logic [DEPTH_BITS-1:0] depth_q, depth_nxt;
	result_t               res;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	kind_t                 out_kind_q;
	logic                  accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	kvpt_step #(.DEPTH_BITS(DEPTH_BITS)) u_step (
		.cur       (st_q),
		.depth     (depth_q),
		.byte_in   (in_ch.byte_in),
		.is_end    (in_ch.is_end),
		.nxt       (st_nxt),
		.depth_nxt (depth_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '{phase: PH_SKIP, opening: 8'h00, closing: CH_SPACE, esc: 1'b0};
			depth_q <= '0;
		end else if (accept) begin
			st_q    <= st_nxt;
			depth_q <= depth_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res.valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload loads only with a new result; holds otherwise
	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			out_char_q <= res.char_v;
			out_kind_q <= res.kind;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.out_kind = out_kind_q;

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.is_end |=> st_q.phase == PH_SKIP && depth_q == '0 && !st_q.esc)
		else $error("end of string did not return parse state to reset");

	a_quoted_depth: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_QUOTED |-> depth_q != '0)
		else $error("quoted value with zero nesting depth");

	a_esc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.esc |-> (st_q.phase == PH_QUOTED || st_q.phase == PH_PLAIN))
		else $error("escape pending outside a value");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while a stalled result would be overwritten");

endmodule
